@@ rtl/core/assert_macros.svh @@
// Shared assertion macros for the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/scs_pkg.sv @@
package scs_pkg;

    localparam int MAX_TERMS  = 16;

    localparam int ANGLE_W    = 32;
    localparam int EPS_W      = 21;
    localparam int RESULT_W   = 32;
    localparam int FRAC_W     = 52;
    localparam int X_W        = 64;
    localparam int ANGLE_SHIFT = FRAC_W - 24;
    localparam int EPS_SHIFT  = FRAC_W - 30;
    localparam int OUT_SHIFT  = FRAC_W - 30;
    localparam int Y_MAG_W    = X_W - OUT_SHIFT;

    // Term and x^2 magnitudes stay below 2^56 once the angle is within [-pi, pi].
    localparam int MAG_W      = 56;
    localparam int LO_W       = 32;
    localparam int PP_W       = 2 * LO_W;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int MRES_W     = PROD_W - FRAC_W;
    localparam int MUL_STEPS  = 4;
    localparam int MUL_CNT_W  = 3;

    localparam int I_W        = $clog2(MAX_TERMS + 1);
    localparam int K_W        = $clog2((2 * MAX_TERMS - 2) * (2 * MAX_TERMS - 1) + 1);

    localparam int DIV_N_W    = 64;
    localparam int DIV_BITS   = 8;
    localparam int DIV_CYC    = DIV_N_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYC);

    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(107);

    localparam logic signed [X_W-1:0] PI_Q52      = 64'sh0032_43F6_A888_5A31;
    localparam logic signed [X_W-1:0] NEG_PI_Q52  = -64'sh0032_43F6_A888_5A31;
    localparam logic signed [X_W-1:0] TWO_PI_Q52  = 64'sh0064_87ED_5110_B461;
    localparam logic signed [X_W-1:0] HALF_PI_Q52 = 64'sh0019_21FB_5444_2D18;

    localparam logic [PROD_W-1:0] MUL_ROUND = PROD_W'(1) << (FRAC_W - 1);
    localparam logic [X_W-1:0]    OUT_ROUND = X_W'(1) << (OUT_SHIFT - 1);

    localparam logic [RESULT_W-2:0]        MAG_ONE    = (RESULT_W - 1)'(1) << 30;
    localparam logic signed [RESULT_W-1:0] RESULT_MAX = 32'sd1073741824;
    localparam logic signed [RESULT_W-1:0] RESULT_MIN = -32'sd1073741824;

    typedef struct packed {
        logic load;
        logic red_step;
        logic flip;
        logic mul_start;
        logic mul_sq;
        logic series_init;
        logic x2_load;
        logic div_start;
        logic term_update;
        logic out_load;
    } scs_cmd_t;

    typedef struct packed {
        logic x_in_range;
        logic req_cos;
        logic mul_done;
        logic div_done;
        logic term_small;
        logic last_term;
        logic out_free;
    } scs_status_t;

    // Series divisor 2i(2i+1) for term index i.
    function automatic logic [K_W-1:0] term_divisor(input logic [I_W-1:0] idx);
        logic [K_W-1:0] two_i;
        two_i = K_W'({idx, 1'b0});
        return K_W'(two_i * (two_i + K_W'(1)));
    endfunction

endpackage

@@ rtl/core/scs_mul.sv @@
module scs_mul import scs_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [MAG_W-1:0]  op_a,
    input  logic [MAG_W-1:0]  op_b,
    output logic              done,
    output logic [MRES_W-1:0] prod_q52
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [MAG_W-1:0]     a_reg;
    logic [MAG_W-1:0]     b_reg;
    logic [PP_W-1:0]      pp_reg;
    logic [PP_W-1:0]      pp_next;
    logic [1:0]           sh_reg;
    logic [1:0]           sh_next;
    logic [PROD_W-1:0]    acc_reg;
    logic [PROD_W-1:0]    pp_shifted;
    logic [LO_W-1:0]      sel_a;
    logic [LO_W-1:0]      sel_b;
    logic                 cnt_last;

    assign cnt_last = (cnt_reg == MUL_CNT_W'(MUL_STEPS));

    // One 32x32 partial product per cycle: lo*lo, lo*hi, hi*lo, hi*hi.
    always_comb begin
        case (cnt_reg)
            3'd0: begin
                sel_a   = a_reg[LO_W-1:0];
                sel_b   = b_reg[LO_W-1:0];
                sh_next = 2'd0;
            end
            3'd1: begin
                sel_a   = a_reg[LO_W-1:0];
                sel_b   = LO_W'(b_reg[MAG_W-1:LO_W]);
                sh_next = 2'd1;
            end
            3'd2: begin
                sel_a   = LO_W'(a_reg[MAG_W-1:LO_W]);
                sel_b   = b_reg[LO_W-1:0];
                sh_next = 2'd1;
            end
            default: begin
                sel_a   = LO_W'(a_reg[MAG_W-1:LO_W]);
                sel_b   = LO_W'(b_reg[MAG_W-1:LO_W]);
                sh_next = 2'd2;
            end
        endcase
        pp_next = PP_W'(sel_a * sel_b);
    end

    always_comb begin
        case (sh_reg)
            2'd0:    pp_shifted = PROD_W'(pp_reg);
            2'd1:    pp_shifted = PROD_W'(pp_reg) << LO_W;
            default: pp_shifted = PROD_W'(pp_reg) << (2 * LO_W);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= MUL_CNT_W'(cnt_reg + 1'b1);
                if (cnt_last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Accumulator starts at half an LSB of Q.52 so the top bits come out rounded.
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= op_a;
            b_reg   <= op_b;
            acc_reg <= MUL_ROUND;
        end else if (busy_reg) begin
            if (!cnt_last) begin
                pp_reg <= pp_next;
                sh_reg <= sh_next;
            end
            if (cnt_reg != '0) begin
                acc_reg <= acc_reg + pp_shifted;
            end
        end
    end

    assign done     = done_reg;
    assign prod_q52 = acc_reg[PROD_W-1:FRAC_W];

endmodule

@@ rtl/core/scs_div.sv @@
module scs_div import scs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [DIV_N_W-1:0] numer,
    input  logic [K_W-1:0]     denom,
    output logic               done,
    output logic [DIV_N_W-1:0] quot
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_N_W-1:0]   num_reg;
    logic [DIV_N_W-1:0]   num_next;
    logic [K_W-1:0]       rem_reg;
    logic [K_W-1:0]       rem_next;
    logic [K_W-1:0]       k_reg;
    logic                 cnt_last;

    assign cnt_last = (cnt_reg == DIV_CNT_W'(DIV_CYC - 1));

    // Restoring division, several quotient bits per cycle; the remainder
    // stays below the small divisor so each step is a narrow compare.
    always_comb begin
        logic [K_W:0] trial;
        num_next = num_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int s = 0; s < DIV_BITS; s++) begin
            trial    = {rem_next, num_next[DIV_N_W-1]};
            num_next = {num_next[DIV_N_W-2:0], 1'b0};
            if (trial >= {1'b0, k_reg}) begin
                rem_next    = K_W'(trial - {1'b0, k_reg});
                num_next[0] = 1'b1;
            end else begin
                rem_next = K_W'(trial);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= DIV_CNT_W'(cnt_reg + 1'b1);
                if (cnt_last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= numer;
            rem_reg <= '0;
            k_reg   <= denom;
        end else if (busy_reg) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

@@ rtl/core/scs_datapath.sv @@
module scs_datapath import scs_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    input  logic [EPS_W-1:0]           cfg_wdata,
    input  logic                       s_req_type,
    input  logic signed [ANGLE_W-1:0]  s_angle,
    input  scs_cmd_t                   cmd,
    output scs_status_t                status,
    input  logic                       m_ready,
    output logic                       m_valid,
    output logic signed [RESULT_W-1:0] m_result
);

    logic [EPS_W-1:0]           eps_reg;
    logic                       req_reg;
    logic signed [X_W-1:0]      x_reg;
    logic signed [X_W-1:0]      x_next;
    logic [MAG_W-1:0]           tmag_reg;
    logic                       tneg_reg;
    logic signed [X_W-1:0]      y_reg;
    logic signed [X_W-1:0]      y_next;
    logic [MAG_W-1:0]           x2_reg;
    logic [I_W-1:0]             i_reg;
    logic                       m_valid_reg;
    logic signed [RESULT_W-1:0] result_reg;
    logic signed [RESULT_W-1:0] result_next;

    logic                       x_gt_pi;
    logic                       x_lt_npi;
    logic [X_W-1:0]             x_abs;
    logic [MAG_W-1:0]           x_mag;
    logic [MAG_W-1:0]           lim;
    logic [MAG_W-1:0]           mul_a;
    logic [MAG_W-1:0]           mul_b;
    logic                       mul_done;
    logic [MRES_W-1:0]          mul_res;
    logic [K_W-1:0]             k_val;
    logic [DIV_N_W-1:0]         div_num;
    logic                       div_done;
    logic [DIV_N_W-1:0]         div_q;
    logic [MAG_W-1:0]           tmag_new;
    logic [X_W-1:0]             term_ext;
    logic [X_W-1:0]             y_abs;
    logic [X_W-1:0]             y_rnd;
    logic [Y_MAG_W-1:0]         y_mag;
    logic [RESULT_W-2:0]        res_mag;
    logic                       out_free;

    assign x_gt_pi  = (x_reg > PI_Q52);
    assign x_lt_npi = (x_reg < NEG_PI_Q52);
    assign x_abs    = x_reg[X_W-1] ? X_W'(-x_reg) : X_W'(x_reg);
    assign x_mag    = x_abs[MAG_W-1:0];
    assign lim      = {{(MAG_W - EPS_W - EPS_SHIFT){1'b0}}, eps_reg, {EPS_SHIFT{1'b0}}};

    always_comb begin
        x_next = x_reg;
        if (cmd.load) begin
            x_next = {{(X_W - ANGLE_W - ANGLE_SHIFT){s_angle[ANGLE_W-1]}},
                      s_angle, {ANGLE_SHIFT{1'b0}}};
        end else if (cmd.red_step) begin
            x_next = x_gt_pi ? x_reg - TWO_PI_Q52 : x_reg + TWO_PI_Q52;
        end else if (cmd.flip) begin
            x_next = HALF_PI_Q52 - x_reg;
        end
    end

    assign mul_a = cmd.mul_sq ? x_mag : tmag_reg;
    assign mul_b = cmd.mul_sq ? x_mag : x2_reg;

    scs_mul u_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.mul_start),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .done     (mul_done),
        .prod_q52 (mul_res)
    );

    // Divisor is even, so half of it is exact.
    assign k_val   = term_divisor(i_reg);
    assign div_num = DIV_N_W'(mul_res) + DIV_N_W'(k_val >> 1);

    scs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .numer   (div_num),
        .denom   (k_val),
        .done    (div_done),
        .quot    (div_q)
    );

    // New term flips sign relative to the previous one.
    assign tmag_new = div_q[MAG_W-1:0];
    assign term_ext = {{(X_W - MAG_W){1'b0}}, tmag_new};
    assign y_next   = tneg_reg ? y_reg + signed'(term_ext) : y_reg - signed'(term_ext);

    // Round half away from zero to Q2.30, clamp to one.
    always_comb begin
        y_abs   = y_reg[X_W-1] ? X_W'(-y_reg) : X_W'(y_reg);
        y_rnd   = y_abs + OUT_ROUND;
        y_mag   = y_rnd[X_W-1:OUT_SHIFT];
        res_mag = (y_mag > Y_MAG_W'(MAG_ONE)) ? MAG_ONE : y_mag[RESULT_W-2:0];
        result_next = y_reg[X_W-1] ? -signed'({1'b0, res_mag}) : signed'({1'b0, res_mag});
    end

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg     <= EPS_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                eps_reg <= cfg_wdata;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        if (cmd.load) begin
            req_reg <= s_req_type;
        end
        if (cmd.series_init) begin
            tmag_reg <= x_mag;
            tneg_reg <= x_reg[X_W-1];
            y_reg    <= x_reg;
            i_reg    <= I_W'(1);
        end else if (cmd.term_update) begin
            tmag_reg <= tmag_new;
            tneg_reg <= ~tneg_reg;
            y_reg    <= y_next;
            i_reg    <= I_W'(i_reg + 1'b1);
        end
        if (cmd.x2_load) begin
            x2_reg <= mul_res[MAG_W-1:0];
        end
        if (cmd.out_load) begin
            result_reg <= result_next;
        end
    end

    always_comb begin
        status.x_in_range = !x_gt_pi && !x_lt_npi;
        status.req_cos    = req_reg;
        status.mul_done   = mul_done;
        status.div_done   = div_done;
        status.term_small = (tmag_reg <= lim);
        status.last_term  = (i_reg == I_W'(MAX_TERMS));
        status.out_free   = out_free;
    end

    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

endmodule

@@ rtl/core/scs_ctrl.sv @@
module scs_ctrl import scs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  scs_status_t status,
    output scs_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RED1 = 4'd1;
    localparam logic [3:0] ST_FLIP = 4'd2;
    localparam logic [3:0] ST_RED2 = 4'd3;
    localparam logic [3:0] ST_SQ   = 4'd4;
    localparam logic [3:0] ST_SQW  = 4'd5;
    localparam logic [3:0] ST_CHK  = 4'd6;
    localparam logic [3:0] ST_MULW = 4'd7;
    localparam logic [3:0] ST_DIVW = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RED1;
                end
            end
            ST_RED1: begin
                if (!status.x_in_range) begin
                    cmd.red_step = 1'b1;
                end else if (status.req_cos) begin
                    state_next = ST_FLIP;
                end else begin
                    state_next = ST_SQ;
                end
            end
            ST_FLIP: begin
                cmd.flip   = 1'b1;
                state_next = ST_RED2;
            end
            ST_RED2: begin
                if (!status.x_in_range) begin
                    cmd.red_step = 1'b1;
                end else begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                cmd.mul_start   = 1'b1;
                cmd.mul_sq      = 1'b1;
                cmd.series_init = 1'b1;
                state_next      = ST_SQW;
            end
            ST_SQW: begin
                if (status.mul_done) begin
                    cmd.x2_load = 1'b1;
                    state_next  = ST_CHK;
                end
            end
            ST_CHK: begin
                // Stop on a small term or once the term cap is reached.
                if (status.last_term || status.term_small) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.mul_start = 1'b1;
                    state_next    = ST_MULW;
                end
            end
            ST_MULW: begin
                if (status.mul_done) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVW;
                end
            end
            ST_DIVW: begin
                if (status.div_done) begin
                    cmd.term_update = 1'b1;
                    state_next      = ST_CHK;
                end
            end
            ST_OUT: begin
                // Hold until the output register can take the result.
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/sine_cosine_series_top.sv @@
// Flow: after the input transfer the angle goes through repeated 2*pi reduction steps into
//   [-pi, pi], then the series runs at most MAX_TERMS-1 terms after the first; cosine adds
//   a flip to pi/2 - x and a second reduction before the series.
// Throughput: one item in flight; each term uses the shared 32x32 multiplier and the
//   8-bit-per-cycle term divider.
// Reset: synchronous active-low aresetn idles the controller, empties the output register
//   and sets the threshold to 107.
module sine_cosine_series_top import scs_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [EPS_W-1:0]           cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_req_type,
    input  logic signed [ANGLE_W-1:0]  s_angle,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [RESULT_W-1:0] m_result
);

    scs_cmd_t    cmd;
    scs_status_t status;

    assign cfg_ready = 1'b1;

    scs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    scs_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_wdata  (cfg_wdata),
        .s_req_type (s_req_type),
        .s_angle    (s_angle),
        .cmd        (cmd),
        .status     (status),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .m_result   (m_result)
    );

endmodule

@@ rtl/core/scs_checker.sv @@
`include "assert_macros.svh"

module scs_checker import scs_pkg::*; (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       cfg_valid,
    input logic                       cfg_ready,
    input logic [EPS_W-1:0]           cfg_wdata,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       s_req_type,
    input logic signed [ANGLE_W-1:0]  s_angle,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic signed [RESULT_W-1:0] m_result
);

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_result), "result dropped or changed while stalled")

    `ASSERT_SAME(a_out_range, aclk, aresetn, m_valid, (m_result <= RESULT_MAX) && (m_result >= RESULT_MIN), "result beyond plus or minus one")

    `ASSERT_NEXT(a_busy_after_take, aclk, aresetn, s_valid && s_ready, !s_ready, "input ready right after a transfer")

    `ASSERT_SAME(a_reset_idle, aclk, aresetn, $past(!aresetn), s_ready && !m_valid, "not idle after reset")

endmodule

bind sine_cosine_series_top scs_checker u_scs_checker (.*);
